>>> sv/stxfr_pkg.sv
// ----------------------------------------------------------------------------
// stxfr_pkg
// shared types and constants of the stx/etx frame receiver
// ----------------------------------------------------------------------------
package stxfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] START_DELIM_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_DELIM_RST   = 8'h03;
    localparam logic [BYTE_W-1:0] MAX_LEN_RST     = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_DELIM = 2'd0,
        CFG_END_DELIM   = 2'd1,
        CFG_MAX_LEN     = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_DATA = 3'd2,
        PH_CHK  = 3'd3,
        PH_END  = 3'd4,
        PH_ERR  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_GOOD   = 3'd1,
        EV_BADSUM = 3'd2,
        EV_BADEND = 3'd3,
        EV_BADLEN = 3'd4
    } event_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_delim;
        logic [BYTE_W-1:0] end_delim;
        logic [BYTE_W-1:0] max_len;
    } cfg_t;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_last;
        event_t            frame_event;
    } res_t;

endpackage

>>> sv/stxfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// stxfr_cfg_regs
// delimiter and length limit registers behind the configuration write port
// ----------------------------------------------------------------------------
module stxfr_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [stxfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stxfr_pkg::BYTE_W-1:0]       cfg_data,
    output stxfr_pkg::cfg_t                    cfg
);
    import stxfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_START_DELIM: cfg_next.start_delim = cfg_data;
                CFG_END_DELIM:   cfg_next.end_delim   = cfg_data;
                CFG_MAX_LEN:     cfg_next.max_len     = cfg_data;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_delim <= START_DELIM_RST;
            cfg_reg.end_delim   <= END_DELIM_RST;
            cfg_reg.max_len     <= MAX_LEN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/stxfr_frame_fsm.sv
// ----------------------------------------------------------------------------
// stxfr_frame_fsm
// frame phase tracking, running xor and per-byte result decode
// ----------------------------------------------------------------------------
module stxfr_frame_fsm (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [stxfr_pkg::BYTE_W-1:0] rx_byte,
    input  stxfr_pkg::cfg_t              cfg,
    output stxfr_pkg::res_t              res
);
    import stxfr_pkg::*;

    phase_t            phase_reg,    phase_next;
    logic [BYTE_W-1:0] exp_len_reg,  exp_len_next;
    logic [BYTE_W-1:0] count_reg,    count_next;
    logic [BYTE_W-1:0] xor_reg,      xor_next;
    logic [BYTE_W-1:0] check_reg,    check_next;
    logic [BYTE_W-1:0] count_inc;
    logic              bad_len;

    assign count_inc = count_reg + 8'd1;
    assign bad_len   = (rx_byte == '0) || (rx_byte > cfg.max_len);

    // next state
    always_comb begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        count_next   = count_reg;
        xor_next     = xor_reg;
        check_next   = check_reg;
        unique case (phase_reg)
            PH_LEN: begin
                exp_len_next = rx_byte;
                count_next   = '0;
                xor_next     = '0;
                phase_next   = bad_len ? PH_ERR : PH_DATA;
            end
            PH_DATA: begin
                xor_next   = xor_reg ^ rx_byte;
                count_next = count_inc;
                if (count_inc >= exp_len_reg) begin
                    phase_next = PH_CHK;
                end
            end
            PH_CHK: begin
                check_next = rx_byte;
                phase_next = PH_END;
            end
            PH_END: begin
                phase_next = PH_HUNT;
            end
            PH_ERR: begin
                count_next = '0;
                phase_next = PH_HUNT;
            end
            default: begin
                phase_next = PH_HUNT;
                if (rx_byte == cfg.start_delim) begin
                    count_next = '0;
                    xor_next   = '0;
                    phase_next = PH_LEN;
                end
            end
        endcase
    end

    // result decode
    always_comb begin
        res = '{payload_valid: 1'b0, payload_byte: '0, payload_last: 1'b0,
                frame_event: EV_NONE};
        unique case (phase_reg)
            PH_LEN: begin
                if (bad_len) begin
                    res.frame_event = EV_BADLEN;
                end
            end
            PH_DATA: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = rx_byte;
                res.payload_last  = (count_inc >= exp_len_reg);
            end
            PH_END: begin
                if (rx_byte == cfg.end_delim) begin
                    res.frame_event = (xor_reg == check_reg) ? EV_GOOD : EV_BADSUM;
                end else begin
                    res.frame_event = EV_BADEND;
                end
            end
            default: begin
                res.frame_event = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            exp_len_reg <= '0;
            count_reg   <= '0;
            xor_reg     <= '0;
            check_reg   <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            count_reg   <= count_next;
            xor_reg     <= xor_next;
            check_reg   <= check_next;
        end
    end

endmodule

>>> sv/stx_etx_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver_unit
// byte-serial deframer for start, length, payload, xor check, end frames
// ----------------------------------------------------------------------------
// One received byte enters per request and exactly one result leaves for it.
// The path is an input register, the frame state update and result decode,
// and a result register; a byte is accepted every cycle while results are
// taken. Payload bytes stream out with a last mark; a bad length byte gives
// bad length, the end byte the outcome: good, checksum mismatch or bad end.
// The three configuration registers are written through the cfg port; the
// user must write them only while idle, which the block does not enforce.
module stx_etx_frame_receiver_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [stxfr_pkg::BYTE_W-1:0]       s_rx_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_payload_valid,
    output logic [stxfr_pkg::BYTE_W-1:0]       m_payload_byte,
    output logic                               m_payload_last,
    output logic [2:0]                         m_frame_event,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [stxfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stxfr_pkg::BYTE_W-1:0]       cfg_data
);
    import stxfr_pkg::*;

    cfg_t              cfg;
    res_t              fsm_res;
    res_t              res_reg;
    logic              res_valid_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              advance;
    logic              step;

    assign advance = !res_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    stxfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stxfr_frame_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (fsm_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (step) begin
            res_valid_reg <= 1'b1;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= fsm_res;
        end
    end

    assign m_valid         = res_valid_reg;
    assign m_payload_valid = res_reg.payload_valid;
    assign m_payload_byte  = res_reg.payload_byte;
    assign m_payload_last  = res_reg.payload_last;
    assign m_frame_event   = res_reg.frame_event;

endmodule
